/* hdl/pht_pkg.sv */
package pht_pkg;

    localparam int MAGIC_CHARS_DEF = 8;
    localparam int NUMBER_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [2:0] KIND_MAGIC  = 3'd0;
    localparam logic [2:0] KIND_WIDTH  = 3'd1;
    localparam logic [2:0] KIND_PIXEL  = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    localparam logic [2:0] ERR_BAD_MAGIC      = 3'd0;
    localparam logic [2:0] ERR_NO_WHITESPACE  = 3'd1;
    localparam logic [2:0] ERR_EXPECT_NUMBER  = 3'd2;
    localparam logic [2:0] ERR_BAD_AFTER_MAX  = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED_END = 3'd4;
    localparam logic [2:0] ERR_NO_IMAGE       = 3'd5;
    localparam logic [2:0] ERR_MAGIC_LONG     = 3'd6;
    localparam logic [2:0] ERR_NUMBER_LARGE   = 3'd7;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [3:0]  mlen;
        logic [2:0]  err;
    } result_t;

    // One accepted byte yields up to two results; cnt says how many are used.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } entry_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic entry_t add_result(input entry_t e, input logic [2:0] kind,
                                          input logic [63:0] value,
                                          input logic [3:0] mlen,
                                          input logic [2:0] err);
        entry_t  o;
        result_t r;
        o       = e;
        r.kind  = kind;
        r.value = value;
        r.mlen  = mlen;
        r.err   = err;
        if (e.cnt == 2'd0)
        begin
            o.r0  = r;
            o.cnt = 2'd1;
        end
        else if (e.cnt == 2'd1)
        begin
            o.r1  = r;
            o.cnt = 2'd2;
        end
        return o;
    endfunction

endpackage

/* hdl/ppm_header_tokenizer_top.sv */
// PPM header tokenizer: bytes of an image file in, header tokens and pixel bytes out.
// Input channel: present data_byte/last_byte with push; a transfer happens on a
// rising edge with push high and full low. last_byte marks the final byte of a file.
// Output channel: while empty is low the oldest result sits on token_kind,
// token_value, magic_length, error_code and last_of_run; pop high with empty low
// transfers it. last_of_run flags the final result caused by one input byte.
// Throughput: one byte per cycle while full is low. The front classifier decides each
// byte combinationally (including the multiply-by-ten accumulate); a byte that yields
// two results (end-of-file token after the last pixel, error after a truncated token)
// is handed out as two results on the output side, absorbed by the four-entry queue.
// With the output side idle, a result is written into the queue when its byte
// transfers in, and the output register then loads it from the queue.
// Bytes that yield no result (whitespace, comments, digits) consume no queue slot.
// Reset: asynchronous, active low; the parser returns to the magic-word start and
// queue and output register are emptied. No clearing pass is needed.
// Stall: when pop stays low the output register holds, the queue fills and full
// rises, holding off the sender without dropping anything.
module ppm_header_tokenizer_top #(
    parameter int MAGIC_CHARS = pht_pkg::MAGIC_CHARS_DEF,
    parameter int NUMBER_BITS = pht_pkg::NUMBER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  token_kind,
    output logic [63:0] token_value,
    output logic [3:0]  magic_length,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    logic             accept;
    logic             q_push;
    pht_pkg::entry_t  q_entry;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    pht_pkg::entry_t  q_head;
    logic             out_valid;
    pht_pkg::result_t out_res;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Front: classify each byte and form its results.
    pht_front #(
        .MAGIC_CHARS (MAGIC_CHARS),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Queue: decouple the classifier from the output side.
    pht_queue #(
        .DEPTH (pht_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_entry),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_entry (q_head)
    );

    // Back: split result pairs and hold one result at the ports.
    pht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (last_of_run)
    );

    assign empty        = !out_valid;
    assign token_kind   = out_res.kind;
    assign token_value  = out_res.value;
    assign magic_length = out_res.mlen;
    assign error_code   = out_res.err;

endmodule

/* hdl/pht_front.sv */
module pht_front #(
    parameter int MAGIC_CHARS = pht_pkg::MAGIC_CHARS_DEF,
    parameter int NUMBER_BITS = pht_pkg::NUMBER_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            q_push,
    output pht_pkg::entry_t q_entry
);

    localparam int MW = 8 * MAGIC_CHARS;

    typedef enum logic [6:0] {
        PH_MAGIC_START = 7'b0000001,
        PH_MAGIC       = 7'b0000010,
        PH_WS          = 7'b0000100,
        PH_NUM         = 7'b0001000,
        PH_SINGLE      = 7'b0010000,
        PH_PIXELS      = 7'b0100000,
        PH_DISCARD     = 7'b1000000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   in_comment_reg, in_comment_next;
    logic                   saw_sep_reg, saw_sep_next;
    logic [MW-1:0]          mag_reg, mag_next;
    logic [NUMBER_BITS-1:0] num_reg, num_next;
    logic [3:0]             cnt_reg, cnt_next;
    pht_pkg::entry_t        ent;

    logic [NUMBER_BITS+3:0] num_ext;
    logic [NUMBER_BITS+3:0] num_mac;

    assign num_ext = (NUMBER_BITS + 4)'(num_reg);
    assign num_mac = (num_ext << 3) + (num_ext << 1) + (NUMBER_BITS + 4)'(data_byte[3:0]);

    always_comb
    begin
        logic go_ws;
        logic go_single;
        logic [2:0] num_kind;
        go_ws           = 1'b0;
        go_single       = 1'b0;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        in_comment_next = in_comment_reg;
        saw_sep_next    = saw_sep_reg;
        mag_next        = mag_reg;
        num_next        = num_reg;
        cnt_next        = cnt_reg;
        ent             = '0;
        num_kind        = {1'b0, idx_reg} + pht_pkg::KIND_WIDTH;

        unique case (phase_reg)
            PH_MAGIC_START:
            begin
                if (pht_pkg::is_alnum(data_byte))
                begin
                    mag_next   = MW'(data_byte);
                    cnt_next   = 4'd1;
                    phase_next = PH_MAGIC;
                    if (last_byte)
                    begin
                        ent = pht_pkg::add_result(ent, pht_pkg::KIND_MAGIC, 64'(data_byte),
                                                  4'd1, 3'd0);
                        ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                                  pht_pkg::ERR_UNEXPECTED_END);
                    end
                end
                else
                begin
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_BAD_MAGIC);
                    phase_next = PH_DISCARD;
                end
            end
            PH_MAGIC:
            begin
                if (pht_pkg::is_alnum(data_byte))
                begin
                    if (cnt_reg >= 4'(MAGIC_CHARS))
                    begin
                        ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                                  pht_pkg::ERR_MAGIC_LONG);
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        mag_next = {mag_reg[MW-9:0], data_byte};
                        cnt_next = cnt_reg + 4'd1;
                        if (last_byte)
                        begin
                            ent = pht_pkg::add_result(ent, pht_pkg::KIND_MAGIC, 64'(mag_next),
                                                      cnt_next, 3'd0);
                            ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                                      pht_pkg::ERR_UNEXPECTED_END);
                        end
                    end
                end
                else
                begin
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_MAGIC, 64'(mag_reg),
                                              cnt_reg, 3'd0);
                    phase_next      = PH_WS;
                    idx_next        = 2'd0;
                    saw_sep_next    = 1'b0;
                    in_comment_next = 1'b0;
                    go_ws           = 1'b1;
                end
            end
            PH_WS:
            begin
                go_ws = 1'b1;
            end
            PH_NUM:
            begin
                if (pht_pkg::is_digit(data_byte))
                begin
                    if (num_mac[NUMBER_BITS+3:NUMBER_BITS] != 4'd0)
                    begin
                        ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                                  pht_pkg::ERR_NUMBER_LARGE);
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        num_next = num_mac[NUMBER_BITS-1:0];
                        if (last_byte)
                        begin
                            ent = pht_pkg::add_result(ent, num_kind, 64'(num_next), '0, '0);
                            ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                                      pht_pkg::ERR_UNEXPECTED_END);
                        end
                    end
                end
                else
                begin
                    ent = pht_pkg::add_result(ent, num_kind, 64'(num_reg), '0, '0);
                    in_comment_next = 1'b0;
                    saw_sep_next    = 1'b0;
                    num_next        = '0;
                    if (idx_reg == 2'd2)
                    begin
                        phase_next = PH_SINGLE;
                        go_single  = 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        phase_next = PH_WS;
                        go_ws      = 1'b1;
                    end
                end
            end
            PH_SINGLE:
            begin
                go_single = 1'b1;
            end
            PH_PIXELS:
            begin
                ent = pht_pkg::add_result(ent, pht_pkg::KIND_PIXEL, 64'(data_byte), '0, '0);
                if (last_byte)
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_END, '0, '0, '0);
            end
            PH_DISCARD:
            begin
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase

        // Whitespace run ahead of a number; a comment holds until line feed.
        if (go_ws)
        begin
            priority if (in_comment_next)
            begin
                if (data_byte == pht_pkg::CH_LF)
                    in_comment_next = 1'b0;
                if (last_byte)
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_UNEXPECTED_END);
            end
            else if (data_byte == pht_pkg::CH_HASH || pht_pkg::is_ws(data_byte))
            begin
                in_comment_next = (data_byte == pht_pkg::CH_HASH);
                saw_sep_next    = 1'b1;
                if (last_byte)
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_UNEXPECTED_END);
            end
            else if (!saw_sep_next)
            begin
                ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                          pht_pkg::ERR_NO_WHITESPACE);
                phase_next = PH_DISCARD;
            end
            else if (pht_pkg::is_digit(data_byte))
            begin
                phase_next = PH_NUM;
                num_next   = NUMBER_BITS'(data_byte[3:0]);
                if (last_byte)
                begin
                    ent = pht_pkg::add_result(ent, {1'b0, idx_next} + pht_pkg::KIND_WIDTH,
                                              64'(data_byte[3:0]), '0, '0);
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_UNEXPECTED_END);
                end
            end
            else
            begin
                ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                          pht_pkg::ERR_EXPECT_NUMBER);
                phase_next = PH_DISCARD;
            end
        end

        // Exactly one separator after maxval: one whitespace byte, or a comment ended by line feed.
        if (go_single)
        begin
            priority if (in_comment_next)
            begin
                if (data_byte == pht_pkg::CH_LF)
                begin
                    in_comment_next = 1'b0;
                    phase_next      = PH_PIXELS;
                end
                if (last_byte)
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_NO_IMAGE);
            end
            else if (data_byte == pht_pkg::CH_HASH || pht_pkg::is_ws(data_byte))
            begin
                if (data_byte == pht_pkg::CH_HASH)
                    in_comment_next = 1'b1;
                else
                    phase_next = PH_PIXELS;
                if (last_byte)
                    ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                              pht_pkg::ERR_NO_IMAGE);
            end
            else
            begin
                ent = pht_pkg::add_result(ent, pht_pkg::KIND_ERROR, '0, '0,
                                          pht_pkg::ERR_BAD_AFTER_MAX);
                phase_next = PH_DISCARD;
            end
        end

        // End of file: start over for the next file.
        if (last_byte)
        begin
            phase_next      = PH_MAGIC_START;
            idx_next        = 2'd0;
            in_comment_next = 1'b0;
            saw_sep_next    = 1'b0;
            mag_next        = '0;
            num_next        = '0;
            cnt_next        = 4'd0;
        end
    end

    assign q_push  = accept && (ent.cnt != 2'd0);
    assign q_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC_START;
            idx_reg        <= 2'd0;
            in_comment_reg <= 1'b0;
            saw_sep_reg    <= 1'b0;
            mag_reg        <= '0;
            num_reg        <= '0;
            cnt_reg        <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            in_comment_reg <= in_comment_next;
            saw_sep_reg    <= saw_sep_next;
            mag_reg        <= mag_next;
            num_reg        <= num_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

/* hdl/pht_queue.sv */
module pht_queue #(
    parameter int DEPTH = pht_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pht_pkg::entry_t wr_entry,
    output logic            q_full,
    input  logic            rd_en,
    output logic            rd_valid,
    output pht_pkg::entry_t rd_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pht_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign q_full   = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

/* hdl/pht_back.sv */
module pht_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  pht_pkg::entry_t q_head,
    output logic            q_pop,
    input  logic            pop,
    output logic            out_valid,
    output pht_pkg::result_t out_res,
    output logic            out_last
);

    logic             valid_reg, valid_next;
    logic             half_reg, half_next;
    pht_pkg::result_t res_reg, res_next;
    logic             last_reg, last_next;
    logic             load;

    // Refill the output register whenever it is empty or being drained and the queue holds an entry.
    assign load = q_valid && (!valid_reg || pop);

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (valid_reg && pop)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (half_reg)
            begin
                res_next  = q_head.r1;
                last_next = 1'b1;
                half_next = 1'b0;
                q_pop     = 1'b1;
            end
            else
            begin
                res_next  = q_head.r0;
                last_next = (q_head.cnt != 2'd2);
                half_next = (q_head.cnt == 2'd2);
                q_pop     = (q_head.cnt != 2'd2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule
